// ----- hw/rtl/sorted_word_count_l1_kernel_unit_assert.svh -----
// Assertion macros for the sorted word count L1 kernel unit.
// Taken in by `include in the RTL files that carry concurrent checks.
`ifndef SORTED_WORD_COUNT_L1_KERNEL_UNIT_ASSERT_SVH
`define SORTED_WORD_COUNT_L1_KERNEL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWL1_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWL1_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/swl1_pkg.sv -----
// Package for the sorted word count L1 kernel unit: widths, constants,
// state types, status structs and the reciprocal table. No dependencies.
`default_nettype none

package swl1_pkg;

    // Defaults for the top level parameters
    localparam int MAX_LEN_DEF   = 256;
    localparam int WORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int IN_WORD_W  = 16;
    localparam int DIST_OUT_W = 10;
    localparam int KERN_W     = 17;
    localparam int CFG_W      = 32;
    localparam int MUL_W      = 32;

    localparam logic [CFG_W-1:0]      RECIP_RESET = 32'h0100_0000;
    localparam logic [DIST_OUT_W-1:0] DIST_SAT    = 10'd1023;

    // Series arithmetic in Q31
    localparam logic [31:0]        Q31_ONE     = 32'h8000_0000;
    localparam logic signed [33:0] SUM_ONE     = 34'sh0_8000_0000;
    localparam logic [3:0]         SERIES_LAST = 4'd14;
    localparam logic [39:0]        EXP_N_LIMIT = 40'd24;
    localparam logic [31:0]        ROUND_HALF  = 32'h0000_4000;
    localparam logic [KERN_W-1:0]  KERN_ONE    = 17'h1_0000;

    // Merge walk sequencer
    typedef enum logic [2:0] {
        W_IDLE,
        W_PRIME,
        W_CMP,
        W_RUN_AE,
        W_RUN_BE,
        W_RUN_A,
        W_RUN_B,
        W_DONE
    } t_walk_state;

    // Kernel evaluation sequencer
    typedef enum logic [3:0] {
        E_IDLE,
        E_SCALE,
        E_SPLIT,
        E_SER_MF,
        E_SER_MR,
        E_SER_MK,
        E_SER_FIX,
        E_SER_END,
        E_POW_MUL,
        E_POW_ACC,
        E_HOLD
    } t_exp_state;

    typedef struct packed {
        logic busy;
        logic done;
        logic mismatch;
        logic overflow;
    } t_walk_status;

    typedef struct packed {
        logic busy;
        logic valid;
    } t_exp_status;

    // floor(2^32 / k) for k = 2..14; k = 1 never uses the table
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd2:    r = 32'd2147483648;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741824;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870912;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            4'd13:   r = 32'd330382099;
            4'd14:   r = 32'd306783378;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/swl1_if.sv -----
// Valid/ready channel interfaces of the sorted word count L1 kernel unit.
// Depends on swl1_pkg for the field widths.
`default_nettype none

// Input channel: one vector element per transaction
interface swl1_in_if;
    logic                           valid;
    logic                           ready;
    logic                           vector_sel;
    logic [swl1_pkg::IN_WORD_W-1:0] word;
    logic                           last;

    modport source (output valid, output vector_sel, output word, output last,
                    input ready);
    modport sink   (input valid, input vector_sel, input word, input last,
                    output ready);
endinterface

// Result channel: one distance / kernel pair per transaction
interface swl1_out_if;
    logic                            valid;
    logic                            ready;
    logic [swl1_pkg::DIST_OUT_W-1:0] distance;
    logic [swl1_pkg::KERN_W-1:0]     kernel_value;
    logic                            length_mismatch;
    logic                            overflow;

    modport source (output valid, output distance, output kernel_value,
                    output length_mismatch, output overflow, input ready);
    modport sink   (input valid, input distance, input kernel_value,
                    input length_mismatch, input overflow, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/swl1_mul.sv -----
// Shared 32x32 unsigned multiplier with registered product.
// Depends on swl1_pkg for the operand width.
`default_nettype none

module swl1_mul (
    input  logic                             i_clk,
    input  logic [swl1_pkg::MUL_W-1:0]       i_a,
    input  logic [swl1_pkg::MUL_W-1:0]       i_b,
    output logic [2*swl1_pkg::MUL_W-1:0]     o_prod
);

    logic [2*swl1_pkg::MUL_W-1:0] r_prod;

    // One product per cycle, no enable: the sequencer reads it in the following cycle
    always_ff @(posedge i_clk) begin
        r_prod <= (2*swl1_pkg::MUL_W)'(i_a) * (2*swl1_pkg::MUL_W)'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- hw/rtl/swl1_walk.sv -----
// Element stores and run-by-run merge walk of the two sorted vectors.
// Depends on swl1_pkg for the sequencer state and status struct.
`default_nettype none

module swl1_walk #(
    parameter int   MAX_LEN   = swl1_pkg::MAX_LEN_DEF,
    parameter int   WORD_BITS = swl1_pkg::WORD_BITS_DEF,
    localparam int  CW        = $clog2(MAX_LEN + 1),
    localparam int  DW        = CW + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic                         i_sel,
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic                         i_last,
    output swl1_pkg::t_walk_status       o_status,
    output logic [DW-1:0]                o_res
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    swl1_pkg::t_walk_state r_state, n_state;

    logic [WORD_BITS-1:0] r_first_store  [MAX_LEN];
    logic [WORD_BITS-1:0] r_second_store [MAX_LEN];

    logic [CW-1:0]        r_cnt_a, r_cnt_b;
    logic                 r_done_a, r_done_b, r_ovf;
    logic [CW-1:0]        r_i, n_i, r_j, n_j, r_ra, n_ra, r_rb, n_rb;
    logic [DW-1:0]        r_res, n_res;
    logic [WORD_BITS-1:0] r_sym, n_sym, r_a_data, r_b_data;
    logic                 r_mismatch, n_mismatch, r_ovf_out, n_ovf_out;

    logic          w_take_a, w_take_b, w_room_a, w_room_b, w_start;
    logic          w_a_ok, w_b_ok, w_a_sym, w_b_sym;
    logic [CW-1:0] w_run_diff;

    // Load side
    assign w_take_a = i_load && !i_sel && !r_done_a;
    assign w_take_b = i_load &&  i_sel && !r_done_b;
    assign w_room_a = r_cnt_a < CW'(MAX_LEN);
    assign w_room_b = r_cnt_b < CW'(MAX_LEN);
    assign w_start  = i_load && (r_done_a || (w_take_a && i_last))
                             && (r_done_b || (w_take_b && i_last));

    // Walk conditions
    assign w_a_ok     = r_i < r_cnt_a;
    assign w_b_ok     = r_j < r_cnt_b;
    assign w_a_sym    = r_a_data == r_sym;
    assign w_b_sym    = r_b_data == r_sym;
    assign w_run_diff = (r_ra > r_rb) ? r_ra - r_rb : r_rb - r_ra;

    // Counts and flags of the pair being loaded; cleared once the walk ends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state == swl1_pkg::W_DONE) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_done_a <= 1'b0;
            r_done_b <= 1'b0;
            r_ovf    <= 1'b0;
        end else begin
            if (w_take_a) begin
                if (w_room_a) r_cnt_a <= r_cnt_a + CW'(1);
                else          r_ovf   <= 1'b1;
                if (i_last)   r_done_a <= 1'b1;
            end
            if (w_take_b) begin
                if (w_room_b) r_cnt_b <= r_cnt_b + CW'(1);
                else          r_ovf   <= 1'b1;
                if (i_last)   r_done_b <= 1'b1;
            end
        end
    end

    // Stores: one write port for loads, registered read at the next walk index
    always_ff @(posedge i_clk) begin
        if (w_take_a && w_room_a) r_first_store[r_cnt_a[AW-1:0]] <= i_word;
        if (w_take_b && w_room_b) r_second_store[r_cnt_b[AW-1:0]] <= i_word;
        r_a_data <= r_first_store[n_i[AW-1:0]];
        r_b_data <= r_second_store[n_j[AW-1:0]];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swl1_pkg::W_IDLE:   if (w_start) n_state = swl1_pkg::W_PRIME;
            swl1_pkg::W_PRIME:  n_state = swl1_pkg::W_CMP;
            swl1_pkg::W_CMP: begin
                if (w_a_ok && w_b_ok) begin
                    if (r_a_data == r_b_data)     n_state = swl1_pkg::W_RUN_AE;
                    else if (r_a_data < r_b_data) n_state = swl1_pkg::W_RUN_A;
                    else                          n_state = swl1_pkg::W_RUN_B;
                end else begin
                    n_state = swl1_pkg::W_DONE;
                end
            end
            swl1_pkg::W_RUN_AE: if (!(w_a_ok && w_a_sym)) n_state = swl1_pkg::W_RUN_BE;
            swl1_pkg::W_RUN_BE: if (!(w_b_ok && w_b_sym)) n_state = swl1_pkg::W_CMP;
            swl1_pkg::W_RUN_A:  if (!(w_a_ok && w_a_sym)) n_state = swl1_pkg::W_CMP;
            swl1_pkg::W_RUN_B:  if (!(w_b_ok && w_b_sym)) n_state = swl1_pkg::W_CMP;
            swl1_pkg::W_DONE:   n_state = swl1_pkg::W_IDLE;
            default:            n_state = swl1_pkg::W_IDLE;
        endcase
    end

    // Walk datapath: indices, run lengths and running sum
    always_comb begin
        n_i        = r_i;
        n_j        = r_j;
        n_ra       = r_ra;
        n_rb       = r_rb;
        n_res      = r_res;
        n_sym      = r_sym;
        n_mismatch = r_mismatch;
        n_ovf_out  = r_ovf_out;
        case (r_state)
            swl1_pkg::W_IDLE: begin
                if (w_start) begin
                    n_i   = '0;
                    n_j   = '0;
                    n_res = '0;
                end
            end
            swl1_pkg::W_CMP: begin
                if (w_a_ok && w_b_ok) begin
                    if (r_a_data == r_b_data) begin
                        n_i   = r_i + CW'(1);
                        n_ra  = CW'(1);
                        n_rb  = '0;
                        n_sym = r_a_data;
                    end else if (r_a_data < r_b_data) begin
                        n_i   = r_i + CW'(1);
                        n_res = r_res + DW'(1);
                        n_sym = r_a_data;
                    end else begin
                        n_j   = r_j + CW'(1);
                        n_res = r_res + DW'(1);
                        n_sym = r_b_data;
                    end
                end else begin
                    // one side exhausted: the rest of both counts unmatched
                    n_res      = r_res + DW'(r_cnt_b - r_j) + DW'(r_cnt_a - r_i);
                    n_mismatch = r_cnt_a != r_cnt_b;
                    n_ovf_out  = r_ovf;
                end
            end
            swl1_pkg::W_RUN_AE: begin
                if (w_a_ok && w_a_sym) begin
                    n_i  = r_i + CW'(1);
                    n_ra = r_ra + CW'(1);
                end
            end
            swl1_pkg::W_RUN_BE: begin
                if (w_b_ok && w_b_sym) begin
                    n_j  = r_j + CW'(1);
                    n_rb = r_rb + CW'(1);
                end else begin
                    n_res = r_res + DW'(w_run_diff);
                end
            end
            swl1_pkg::W_RUN_A: begin
                if (w_a_ok && w_a_sym) begin
                    n_i   = r_i + CW'(1);
                    n_res = r_res + DW'(1);
                end
            end
            swl1_pkg::W_RUN_B: begin
                if (w_b_ok && w_b_sym) begin
                    n_j   = r_j + CW'(1);
                    n_res = r_res + DW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swl1_pkg::W_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ra       <= n_ra;
        r_rb       <= n_rb;
        r_res      <= n_res;
        r_sym      <= n_sym;
        r_mismatch <= n_mismatch;
        r_ovf_out  <= n_ovf_out;
    end

    // Status outputs
    always_comb begin
        o_status.busy     = r_state != swl1_pkg::W_IDLE;
        o_status.done     = r_state == swl1_pkg::W_DONE;
        o_status.mismatch = r_mismatch;
        o_status.overflow = r_ovf_out;
        o_res             = r_res;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/swl1_exp.sv -----
// Kernel evaluation exp(-d * recip_width) on one shared multiplier.
// Depends on swl1_pkg and instantiates swl1_mul.
`default_nettype none

module swl1_exp #(
    parameter int DIST_W = $clog2(swl1_pkg::MAX_LEN_DEF + 1) + 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DIST_W-1:0]              i_dist,
    input  logic [swl1_pkg::CFG_W-1:0]     i_recip,
    input  logic                           i_res_ready,
    output swl1_pkg::t_exp_status          o_status,
    output logic [swl1_pkg::KERN_W-1:0]    o_kernel
);

    localparam int MW = swl1_pkg::MUL_W;

    swl1_pkg::t_exp_state r_state, n_state;

    logic [MW-1:0]        w_op_a, w_op_b;
    logic [2*MW-1:0]      w_prod;

    logic [31:0]          r_term, n_term, r_e1, n_e1, r_r, n_r, r_p, n_p, r_q0, n_q0;
    logic signed [33:0]   r_sum, n_sum;
    logic [3:0]           r_k, n_k;
    logic                 r_pass, n_pass;
    logic [30:0]          r_f31, n_f31;
    logic [4:0]           r_n, n_n, r_cnt, n_cnt;

    logic [31:0]          w_p, w_f_op, w_rem, w_q, w_clamp, w_round;
    logic                 w_big;

    // Product fields used across the phases
    assign w_p     = w_prod[62:31];
    assign w_f_op  = r_pass ? {1'b0, r_f31} : swl1_pkg::Q31_ONE;
    assign w_rem   = r_p - w_prod[31:0];
    assign w_q     = r_q0 + ((w_rem >= 32'(r_k)) ? 32'd1 : 32'd0);
    assign w_big   = w_prod[63:24] >= swl1_pkg::EXP_N_LIMIT;
    assign w_clamp = r_sum[33] ? 32'd0 :
                     (r_sum > swl1_pkg::SUM_ONE) ? swl1_pkg::Q31_ONE : r_sum[31:0];
    assign w_round = r_r + swl1_pkg::ROUND_HALF;

    swl1_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_prod (w_prod)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            swl1_pkg::E_IDLE:    if (i_start) n_state = swl1_pkg::E_SCALE;
            swl1_pkg::E_SCALE:   n_state = swl1_pkg::E_SPLIT;
            swl1_pkg::E_SPLIT:   n_state = w_big ? swl1_pkg::E_HOLD : swl1_pkg::E_SER_MF;
            swl1_pkg::E_SER_MF:  n_state = swl1_pkg::E_SER_MR;
            swl1_pkg::E_SER_MR:  n_state = (r_k == 4'd1) ? swl1_pkg::E_SER_MF
                                                         : swl1_pkg::E_SER_MK;
            swl1_pkg::E_SER_MK:  n_state = swl1_pkg::E_SER_FIX;
            swl1_pkg::E_SER_FIX: n_state = (r_k == swl1_pkg::SERIES_LAST)
                                           ? swl1_pkg::E_SER_END : swl1_pkg::E_SER_MF;
            swl1_pkg::E_SER_END: begin
                if (!r_pass)          n_state = swl1_pkg::E_SER_MF;
                else if (r_n == '0)   n_state = swl1_pkg::E_HOLD;
                else                  n_state = swl1_pkg::E_POW_MUL;
            end
            swl1_pkg::E_POW_MUL: n_state = swl1_pkg::E_POW_ACC;
            swl1_pkg::E_POW_ACC: n_state = (r_cnt + 5'd1 == r_n) ? swl1_pkg::E_HOLD
                                                                 : swl1_pkg::E_POW_MUL;
            swl1_pkg::E_HOLD:    if (i_res_ready) n_state = swl1_pkg::E_IDLE;
            default:             n_state = swl1_pkg::E_IDLE;
        endcase
    end

    // Outputs: multiplier operands and status
    always_comb begin
        w_op_a = '0;
        w_op_b = '0;
        case (r_state)
            swl1_pkg::E_SCALE: begin
                w_op_a = MW'(i_dist);
                w_op_b = i_recip;
            end
            swl1_pkg::E_SER_MF: begin
                w_op_a = r_term;
                w_op_b = w_f_op;
            end
            swl1_pkg::E_SER_MR: begin
                w_op_a = w_p;
                w_op_b = swl1_pkg::recip_k(r_k);
            end
            swl1_pkg::E_SER_MK: begin
                w_op_a = w_prod[63:32];
                w_op_b = MW'(r_k);
            end
            swl1_pkg::E_POW_MUL: begin
                w_op_a = r_r;
                w_op_b = r_e1;
            end
            default: ;
        endcase
        o_status.busy  = r_state != swl1_pkg::E_IDLE;
        o_status.valid = r_state == swl1_pkg::E_HOLD;
        o_kernel       = w_round[31:15];
    end

    // Datapath: series terms, running sum, power loop
    always_comb begin
        n_term = r_term;
        n_sum  = r_sum;
        n_k    = r_k;
        n_pass = r_pass;
        n_f31  = r_f31;
        n_n    = r_n;
        n_cnt  = r_cnt;
        n_e1   = r_e1;
        n_r    = r_r;
        n_p    = r_p;
        n_q0   = r_q0;
        case (r_state)
            swl1_pkg::E_SPLIT: begin
                if (w_big) begin
                    n_r = '0;
                end else begin
                    // integer part and fraction of x; e^-1 is evaluated first
                    n_n    = w_prod[28:24];
                    n_f31  = {w_prod[23:0], 7'd0};
                    n_pass = 1'b0;
                    n_term = swl1_pkg::Q31_ONE;
                    n_sum  = swl1_pkg::SUM_ONE;
                    n_k    = 4'd1;
                end
            end
            swl1_pkg::E_SER_MR: begin
                n_p = w_p;
                if (r_k == 4'd1) begin
                    n_term = w_p;
                    n_sum  = r_sum - $signed({2'b00, w_p});
                    n_k    = 4'd2;
                end
            end
            swl1_pkg::E_SER_MK: n_q0 = w_prod[63:32];
            swl1_pkg::E_SER_FIX: begin
                n_term = w_q;
                n_sum  = r_k[0] ? r_sum - $signed({2'b00, w_q})
                                : r_sum + $signed({2'b00, w_q});
                n_k    = r_k + 4'd1;
            end
            swl1_pkg::E_SER_END: begin
                if (!r_pass) begin
                    n_e1   = w_clamp;
                    n_pass = 1'b1;
                    n_term = swl1_pkg::Q31_ONE;
                    n_sum  = swl1_pkg::SUM_ONE;
                    n_k    = 4'd1;
                end else begin
                    n_r   = w_clamp;
                    n_cnt = '0;
                end
            end
            swl1_pkg::E_POW_ACC: begin
                n_r   = w_p;
                n_cnt = r_cnt + 5'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= swl1_pkg::E_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_sum  <= n_sum;
        r_k    <= n_k;
        r_pass <= n_pass;
        r_f31  <= n_f31;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_e1   <= n_e1;
        r_r    <= n_r;
        r_p    <= n_p;
        r_q0   <= n_q0;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_word_count_l1_kernel_unit.sv -----
// Channel      | Dir | Fields                                        | Transaction
// -------------+-----+-----------------------------------------------+----------------------
// i_in         | in  | vector_sel, word[15:0], last                  | valid & ready
// o_out        | out | distance[9:0], kernel_value[16:0],            | valid & ready
//              |     | length_mismatch, overflow                     |
// i_cfg_we/..  | in  | i_cfg_wdata[31:0] = recip_width (UQ8.24)      | i_cfg_we high
//
// Elements load back to back while i_in.ready is high; the one closing the second vector
// starts the merge walk over every stored element and run change. The kernel then evaluates
// e^-1 and e^-f by series (f = fraction of x = d * recip_width) and multiplies by e^-1 n
// times (n = integer part of x, below 24), on the single 32x32 multiplier. i_in.ready is
// low from the closing element until the kernel result reaches the output register; a full,
// stalled output register holds one result while the kernel holds the next; no pair loads.
// Reset is synchronous, active low; stores need no clearing and recip_width returns to 1.0.
`default_nettype none
`include "sorted_word_count_l1_kernel_unit_assert.svh"

module sorted_word_count_l1_kernel_unit #(
    parameter int MAX_LEN   = swl1_pkg::MAX_LEN_DEF,
    parameter int WORD_BITS = swl1_pkg::WORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swl1_in_if.sink                       i_in,
    swl1_out_if.source                    o_out,
    input  logic                          i_cfg_we,
    input  logic [swl1_pkg::CFG_W-1:0]    i_cfg_wdata
);

    localparam int DIST_W = $clog2(MAX_LEN + 1) + 1;
    localparam int OUT_W  = swl1_pkg::DIST_OUT_W;
    localparam int SAT_W  = (DIST_W > OUT_W) ? DIST_W : OUT_W;

    logic [swl1_pkg::CFG_W-1:0]   r_recip;
    swl1_pkg::t_walk_status       w_walk_st;
    swl1_pkg::t_exp_status        w_exp_st;
    logic [DIST_W-1:0]            w_res;
    logic [swl1_pkg::KERN_W-1:0]  w_kernel;
    logic                         w_load, w_out_free;
    logic [SAT_W-1:0]             w_dist_ext;
    logic [OUT_W-1:0]             w_dist_sat;

    logic                         r_out_valid;
    logic [OUT_W-1:0]             r_out_dist;
    logic [swl1_pkg::KERN_W-1:0]  r_out_kern;
    logic                         r_out_mis, r_out_ovf;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_recip <= swl1_pkg::RECIP_RESET;
        else if (i_cfg_we) r_recip <= i_cfg_wdata;
    end

    // Input handshake: elements are taken whenever neither sequencer runs
    assign i_in.ready = !w_walk_st.busy && !w_exp_st.busy;
    assign w_load     = i_in.valid && i_in.ready;

    swl1_walk #(
        .MAX_LEN   (MAX_LEN),
        .WORD_BITS (WORD_BITS)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_sel    (i_in.vector_sel),
        .i_word   (WORD_BITS'(i_in.word)),
        .i_last   (i_in.last),
        .o_status (w_walk_st),
        .o_res    (w_res)
    );

    swl1_exp #(
        .DIST_W (DIST_W)
    ) u_exp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_walk_st.done),
        .i_dist      (w_res),
        .i_recip     (r_recip),
        .i_res_ready (w_out_free),
        .o_status    (w_exp_st),
        .o_kernel    (w_kernel)
    );

    // Distance saturation
    assign w_dist_ext = SAT_W'(w_res);
    assign w_dist_sat = (w_dist_ext > SAT_W'(swl1_pkg::DIST_SAT)) ? swl1_pkg::DIST_SAT
                                                                  : w_dist_ext[OUT_W-1:0];

    // Output register
    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                        r_out_valid <= 1'b0;
        else if (w_exp_st.valid && w_out_free) r_out_valid <= 1'b1;
        else if (o_out.ready)                r_out_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (w_exp_st.valid && w_out_free) begin
            r_out_dist <= w_dist_sat;
            r_out_kern <= w_kernel;
            r_out_mis  <= w_walk_st.mismatch;
            r_out_ovf  <= w_walk_st.overflow;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.distance        = r_out_dist;
    assign o_out.kernel_value    = r_out_kern;
    assign o_out.length_mismatch = r_out_mis;
    assign o_out.overflow        = r_out_ovf;

    // Checks
    `SWL1_ASSERT_NOW(a_walk_exp_free, i_clk, i_rst_n, w_walk_st.done, !w_exp_st.busy, "walk finished while kernel unit busy")
    `SWL1_ASSERT_NEXT(a_exp_follows, i_clk, i_rst_n, w_walk_st.done, w_exp_st.busy, "kernel unit did not start after walk")
    `SWL1_ASSERT_NOW(a_kernel_range, i_clk, i_rst_n, o_out.valid, o_out.kernel_value <= swl1_pkg::KERN_ONE, "kernel value above one")
    `SWL1_ASSERT_NOW(a_zero_dist, i_clk, i_rst_n, o_out.valid && (o_out.distance == '0), o_out.kernel_value == swl1_pkg::KERN_ONE, "zero distance without unit kernel")
    `SWL1_ASSERT_NOW(a_parity, i_clk, i_rst_n, (2 * MAX_LEN <= 1023) && o_out.valid && !o_out.length_mismatch, !o_out.distance[0], "odd distance on equal lengths")

endmodule

`default_nettype wire
